// ----- rtl/tld_pkg.sv -----
// Package for the tty line discipline: sizes, result kinds, register indexes,
// character codes and the command record passed from front to back.
// No dependencies.
`timescale 1ns / 1ps

package tld_pkg;

  localparam int LINE_BYTES  = 1024;
  localparam int READ_BURST  = 64;
  localparam int ADDR_W      = $clog2(LINE_BYTES);
  localparam int PTR_W       = ADDR_W + 1;
  localparam int CNT_W       = 7;
  localparam int KIND_W      = 3;
  localparam int BYTE_W      = 8;
  localparam int ERASE_W     = 10;
  localparam int ERASE_MAX   = (1 << ERASE_W) - 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;

  localparam logic [KIND_W-1:0] KIND_ECHO_BYTE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ECHO_ERASE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ECHO_CRLF  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DATA       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EOF        = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NONE       = 3'd5;
  localparam logic [KIND_W-1:0] KIND_REFUSED    = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_CANONICAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_CR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EOF_CHAR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KILL      = 3'd5;

  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_BS = 8'h08;

  // one queued command: a single result, or a data burst (addr, len)
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  byte_value;
    logic [ERASE_W-1:0] erase_count;
    logic [ADDR_W-1:0]  addr;
    logic [CNT_W-1:0]   len;
  } cmd_t;

  typedef struct packed {
    logic burst_done;
  } back_status_t;

endpackage

// ----- rtl/tld_in_if.sv -----
// Input channel of the tty line discipline: valid/ready plus item payload.
// Depends on tld_pkg.
`timescale 1ns / 1ps

interface tld_in_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [tld_pkg::BYTE_W-1:0] char_in;
  logic [tld_pkg::CNT_W-1:0]  read_count;

  modport source (output valid, output mode, output char_in, output read_count, input ready);
  modport sink   (input valid, input mode, input char_in, input read_count, output ready);
endinterface

// ----- rtl/tld_out_if.sv -----
// Result channel of the tty line discipline: valid/ready plus result payload.
// Depends on tld_pkg.
`timescale 1ns / 1ps

interface tld_out_if;
  logic                        valid;
  logic                        ready;
  logic [tld_pkg::KIND_W-1:0]  kind;
  logic [tld_pkg::BYTE_W-1:0]  byte_value;
  logic [tld_pkg::ERASE_W-1:0] erase_count;
  logic                        last;

  modport source (output valid, output kind, output byte_value, output erase_count,
                  output last, input ready);
  modport sink   (input valid, input kind, input byte_value, input erase_count,
                  input last, output ready);
endinterface

// ----- rtl/tld_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module tld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/tld_front.sv -----
// Front end: configuration registers, item classification, line state,
// line store writes and command generation. Depends on tld_pkg, tld_in_if.
`timescale 1ns / 1ps

module tld_front (
  input  logic                          clk,
  input  logic                          rst_n,
  tld_in_if.sink                        in_ch,
  input  logic                          cfg_we,
  input  logic [tld_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tld_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          q_full,
  input  tld_pkg::back_status_t         bk_status,
  output logic                          push,
  output tld_pkg::cmd_t                 push_cmd,
  output logic                          st_we,
  output logic [tld_pkg::ADDR_W-1:0]    st_waddr,
  output logic [tld_pkg::BYTE_W-1:0]    st_wdata
);

  localparam logic [tld_pkg::PTR_W-1:0] CAP = tld_pkg::PTR_W'(tld_pkg::LINE_BYTES - 1);
  localparam logic [tld_pkg::PTR_W-1:0] FULL = tld_pkg::PTR_W'(tld_pkg::LINE_BYTES);
  localparam logic [tld_pkg::CNT_W-1:0] BURST = tld_pkg::CNT_W'(tld_pkg::READ_BURST);

  logic                         canon_r, echo_r, map_cr_r;
  logic [tld_pkg::BYTE_W-1:0]   eof_char_r, erase_char_r, kill_char_r;
  logic [tld_pkg::PTR_W-1:0]    fill_r, fill_nxt, rd_r, rd_nxt;
  logic                         ready_r, ready_nxt, eofp_r, eofp_nxt, busy_r, busy_nxt;

  logic                         accept;
  logic [tld_pkg::BYTE_W-1:0]   c;
  logic [tld_pkg::PTR_W-1:0]    fill_inc, avail;
  logic [tld_pkg::CNT_W-1:0]    want, n;
  logic [tld_pkg::ERASE_W-1:0]  kill_cnt;

  assign in_ch.ready = !q_full && !busy_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign c           = (map_cr_r && in_ch.char_in == tld_pkg::CH_CR) ? tld_pkg::CH_LF
                                                                       : in_ch.char_in;
  assign fill_inc    = fill_r + 1'b1;
  assign avail       = (fill_r > rd_r) ? fill_r - rd_r : '0;
  assign want        = (in_ch.read_count > BURST) ? BURST : in_ch.read_count;
  assign n           = (int'(avail) < int'(want)) ? tld_pkg::CNT_W'(avail) : want;
  assign kill_cnt    = (int'(fill_r) > tld_pkg::ERASE_MAX) ? tld_pkg::ERASE_W'(tld_pkg::ERASE_MAX)
                                                            : tld_pkg::ERASE_W'(fill_r);

  always_comb begin
    fill_nxt = fill_r;
    rd_nxt   = rd_r;
    ready_nxt = ready_r;
    eofp_nxt = eofp_r;
    busy_nxt = busy_r && !bk_status.burst_done;
    push     = 1'b0;
    push_cmd = '0;
    st_we    = 1'b0;
    st_waddr = tld_pkg::ADDR_W'(fill_r);
    st_wdata = c;
    if (accept) begin
      if (!in_ch.mode) begin
        if (!canon_r) begin
          if (fill_r >= CAP) begin
            push = 1'b1;
            push_cmd.kind = tld_pkg::KIND_REFUSED;
          end else begin
            st_we    = 1'b1;
            fill_nxt = fill_inc;
            push     = echo_r;
            push_cmd.kind = tld_pkg::KIND_ECHO_BYTE;
            push_cmd.byte_value = c;
          end
        end else if (ready_r) begin
          push = 1'b1;
          push_cmd.kind = tld_pkg::KIND_REFUSED;
        end else if (c == eof_char_r) begin
          if (fill_r == '0) begin
            eofp_nxt = 1'b1;
          end else begin
            ready_nxt = 1'b1;
          end
        end else if (c == erase_char_r || c == tld_pkg::CH_BS) begin
          if (fill_r != '0) begin
            fill_nxt = fill_r - 1'b1;
            push     = echo_r;
            push_cmd.kind = tld_pkg::KIND_ECHO_ERASE;
            push_cmd.erase_count = tld_pkg::ERASE_W'(1);
          end
        end else if (c == kill_char_r) begin
          fill_nxt = '0;
          push     = echo_r && (fill_r != '0);
          push_cmd.kind = tld_pkg::KIND_ECHO_ERASE;
          push_cmd.erase_count = kill_cnt;
        end else begin
          st_we    = fill_r < FULL;
          fill_nxt = fill_inc;
          push     = echo_r;
          if (c == tld_pkg::CH_LF) begin
            ready_nxt = 1'b1;
            push_cmd.kind = tld_pkg::KIND_ECHO_CRLF;
          end else begin
            ready_nxt = fill_inc >= CAP;
            push_cmd.kind = tld_pkg::KIND_ECHO_BYTE;
            push_cmd.byte_value = c;
          end
        end
      end else begin
        push = 1'b1;
        if (in_ch.read_count == '0) begin
          push_cmd.kind = tld_pkg::KIND_NONE;
        end else if (eofp_r) begin
          eofp_nxt = 1'b0;
          push_cmd.kind = tld_pkg::KIND_EOF;
        end else if (avail == '0 || (canon_r && !ready_r)) begin
          push_cmd.kind = tld_pkg::KIND_NONE;
        end else begin
          push_cmd.kind = tld_pkg::KIND_DATA;
          push_cmd.addr = tld_pkg::ADDR_W'(rd_r);
          push_cmd.len  = n;
          busy_nxt      = 1'b1;
          if (tld_pkg::PTR_W'(n) == avail) begin
            rd_nxt    = '0;
            fill_nxt  = '0;
            ready_nxt = 1'b0;
          end else begin
            rd_nxt = rd_r + tld_pkg::PTR_W'(n);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canon_r      <= 1'b1;
      echo_r       <= 1'b1;
      map_cr_r     <= 1'b1;
      eof_char_r   <= 8'd4;
      erase_char_r <= 8'd127;
      kill_char_r  <= 8'd21;
      fill_r       <= '0;
      rd_r         <= '0;
      ready_r      <= 1'b0;
      eofp_r       <= 1'b0;
      busy_r       <= 1'b0;
    end else begin
      fill_r  <= fill_nxt;
      rd_r    <= rd_nxt;
      ready_r <= ready_nxt;
      eofp_r  <= eofp_nxt;
      busy_r  <= busy_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          tld_pkg::CFG_CANONICAL: canon_r      <= cfg_data[0];
          tld_pkg::CFG_ECHO:      echo_r       <= cfg_data[0];
          tld_pkg::CFG_MAP_CR:    map_cr_r     <= cfg_data[0];
          tld_pkg::CFG_EOF_CHAR:  eof_char_r   <= cfg_data;
          tld_pkg::CFG_ERASE:     erase_char_r <= cfg_data;
          tld_pkg::CFG_KILL:      kill_char_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- rtl/tld_cmd_queue.sv -----
// Short command queue between front and back ends.
// Depends on tld_pkg.
`timescale 1ns / 1ps

module tld_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tld_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          nonempty,
  output tld_pkg::cmd_t head
);

  tld_pkg::cmd_t                entry_r [tld_pkg::QUEUE_DEPTH];
  logic [tld_pkg::QPTR_W-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [tld_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign full     = cnt_r == tld_pkg::QCNT_W'(tld_pkg::QUEUE_DEPTH);
  assign nonempty = cnt_r != '0;
  assign head     = entry_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (int'(wr_r) == tld_pkg::QUEUE_DEPTH - 1) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (int'(rd_r) == tld_pkg::QUEUE_DEPTH - 1) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/tld_back.sv -----
// Back end: executes queued commands, streams data bursts out of the line
// store and drives the result register. Depends on tld_pkg, tld_out_if.
`timescale 1ns / 1ps

module tld_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_nonempty,
  input  tld_pkg::cmd_t               q_head,
  output logic                        q_pop,
  output logic                        st_re,
  output logic [tld_pkg::ADDR_W-1:0]  st_raddr,
  input  logic [tld_pkg::BYTE_W-1:0]  st_rdata,
  output tld_pkg::back_status_t       bk_status,
  tld_out_if.source                   out_ch
);

  logic [tld_pkg::CNT_W-1:0]   rem_r, rem_nxt;
  logic [tld_pkg::ADDR_W-1:0]  raddr_r, raddr_nxt;
  logic                        rv_r, rv_nxt, rlast_r, rlast_nxt;
  logic                        ov_r, ov_nxt, olast_r, olast_nxt;
  logic [tld_pkg::KIND_W-1:0]  okind_r, okind_nxt;
  logic [tld_pkg::BYTE_W-1:0]  obyte_r, obyte_nxt;
  logic [tld_pkg::ERASE_W-1:0] ocnt_r, ocnt_nxt;

  logic out_free, move, issue, start;

  assign out_free = !ov_r || out_ch.ready;
  assign move     = rv_r && out_free;
  assign issue    = (rem_r != '0) && (!rv_r || move);
  assign start    = (rem_r == '0) && !rv_r && q_nonempty;

  assign st_re    = issue;
  assign st_raddr = raddr_r;
  assign bk_status.burst_done = move && rlast_r;

  always_comb begin
    rem_nxt   = rem_r;
    raddr_nxt = raddr_r;
    rv_nxt    = rv_r;
    rlast_nxt = rlast_r;
    ov_nxt    = ov_r;
    olast_nxt = olast_r;
    okind_nxt = okind_r;
    obyte_nxt = obyte_r;
    ocnt_nxt  = ocnt_r;
    q_pop     = 1'b0;

    if (issue) begin
      rem_nxt   = rem_r - 1'b1;
      raddr_nxt = raddr_r + 1'b1;
      rv_nxt    = 1'b1;
      rlast_nxt = rem_r == tld_pkg::CNT_W'(1);
    end else if (move) begin
      rv_nxt = 1'b0;
    end

    if (start && q_head.kind == tld_pkg::KIND_DATA) begin
      q_pop     = 1'b1;
      rem_nxt   = q_head.len;
      raddr_nxt = q_head.addr;
    end

    if (move) begin
      ov_nxt    = 1'b1;
      okind_nxt = tld_pkg::KIND_DATA;
      obyte_nxt = st_rdata;
      ocnt_nxt  = '0;
      olast_nxt = rlast_r;
    end else if (start && q_head.kind != tld_pkg::KIND_DATA && out_free) begin
      q_pop     = 1'b1;
      ov_nxt    = 1'b1;
      okind_nxt = q_head.kind;
      obyte_nxt = q_head.byte_value;
      ocnt_nxt  = q_head.erase_count;
      olast_nxt = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      rv_r  <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      rem_r <= rem_nxt;
      rv_r  <= rv_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    raddr_r <= raddr_nxt;
    rlast_r <= rlast_nxt;
    olast_r <= olast_nxt;
    okind_r <= okind_nxt;
    obyte_r <= obyte_nxt;
    ocnt_r  <= ocnt_nxt;
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.kind        = okind_r;
  assign out_ch.byte_value  = obyte_r;
  assign out_ch.erase_count = ocnt_r;
  assign out_ch.last        = olast_r;

endmodule

// ----- rtl/tty_line_discipline_top.sv -----
// Top level of the tty line discipline: front end, command queue, back end
// and line store. Depends on tld_pkg, tld_in_if, tld_out_if and all submodules.
//
//   port      dir    handshake      payload
//   in_ch     sink   valid/ready    mode, char_in, read_count
//   out_ch    source valid/ready    kind, byte_value, erase_count, last
//   cfg_*     sink   cfg_we only    cfg_index, cfg_data
//
// A character item's result, if it has one, is queued and then held in the result register.
// A read of n bytes goes through the queue, the burst counter and the registered
// store read, then one byte per cycle unless stalled, via the store's single read port.
// New items wait while a data burst is still being read from the store.
// Reset is synchronous; the line store has no reset and no clearing pass.
// A stalled output holds its result; the two-entry queue absorbs short stalls.
`timescale 1ns / 1ps

module tty_line_discipline_top (
  input  logic                           clk,
  input  logic                           rst_n,
  tld_in_if.sink                         in_ch,
  tld_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [tld_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tld_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                       push, pop, q_full, q_nonempty;
  tld_pkg::cmd_t              push_cmd, q_head;
  tld_pkg::back_status_t      bk_status;
  logic                       st_we, st_re;
  logic [tld_pkg::ADDR_W-1:0] st_waddr, st_raddr;
  logic [tld_pkg::BYTE_W-1:0] st_wdata, st_rdata;

  tld_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .bk_status (bk_status),
    .push      (push),
    .push_cmd  (push_cmd),
    .st_we     (st_we),
    .st_waddr  (st_waddr),
    .st_wdata  (st_wdata)
  );

  tld_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  tld_ram #(
    .WIDTH (tld_pkg::BYTE_W),
    .DEPTH (tld_pkg::LINE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  tld_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (pop),
    .st_re      (st_re),
    .st_raddr   (st_raddr),
    .st_rdata   (st_rdata),
    .bk_status  (bk_status),
    .out_ch     (out_ch)
  );

endmodule

// ----- rtl/tld_checker.sv -----
// Port-level checks for the tty line discipline, bound to the top level.
// Depends on tld_pkg and tty_line_discipline_top.
`timescale 1ns / 1ps

module tld_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tld_pkg::KIND_W-1:0]   out_kind,
  input logic [tld_pkg::BYTE_W-1:0]   out_byte,
  input logic [tld_pkg::ERASE_W-1:0]  out_count,
  input logic                         out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte)
      && $stable(out_count) && $stable(out_last))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != tld_pkg::KIND_ECHO_BYTE && out_kind != tld_pkg::KIND_DATA
      |-> out_byte == '0)
    else $error("byte set on a kind without a byte");

  a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != tld_pkg::KIND_ECHO_ERASE |-> out_count == '0)
    else $error("erase count set on a kind without a count");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != tld_pkg::KIND_DATA |-> out_last)
    else $error("single result without last");

endmodule

bind tty_line_discipline_top tld_checker u_tld_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.kind),
  .out_byte  (out_ch.byte_value),
  .out_count (out_ch.erase_count),
  .out_last  (out_ch.last)
);
